@@ rtl/assert_macros.svh @@
// Assertion macros used by the RTL top file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks an implication that must hold in the same cycle.
`define ASSERT_SAME(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("same-cycle assertion failed");

// Checks an implication that must hold in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("next-cycle assertion failed");

`endif

@@ rtl/ssh1d_pkg.sv @@
package ssh1d_pkg;

    localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
    localparam int          MIN_LENGTH = 5;
    localparam int          PAD_ALIGN  = 8;

    typedef enum logic [2:0] {
        PH_LENGTH  = 3'd0,
        PH_PADDING = 3'd1,
        PH_TYPE    = 3'd2,
        PH_DATA    = 3'd3,
        PH_CRC     = 3'd4,
        PH_HALTED  = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        KIND_TYPE   = 2'd0,
        KIND_DATA   = 2'd1,
        KIND_STATUS = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_CRC = 2'd1,
        ST_BAD_LEN = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0] data;
        kind_t      kind;
        status_t    status;
        logic       last;
    } out_item_t;

    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

@@ rtl/ssh1d_in_stage.sv @@
module ssh1d_in_stage (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       take,
    output logic       s_valid,
    output logic [7:0] s_byte
);

    logic       valid_reg;
    logic [7:0] byte_reg;

    assign in_ready = !valid_reg || take;
    assign s_valid  = valid_reg;
    assign s_byte   = byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            valid_reg <= 1'b1;
        end
        else if (take)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= in_byte;
        end
    end

endmodule

@@ rtl/ssh1d_core.sv @@
module ssh1d_core #(
    parameter int MAX_LENGTH_LIMIT = 262144
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [18:0]          wr_data,
    input  logic                 s_valid,
    input  logic [7:0]           s_byte,
    output logic                 take,
    input  logic                 out_ready,
    output logic                 out_valid,
    output ssh1d_pkg::out_item_t out_item
);

    localparam logic [31:0] LIMIT_CAP = 32'(MAX_LENGTH_LIMIT);

    logic [18:0]          max_length_reg;
    ssh1d_pkg::phase_t    phase_reg, phase_next;
    logic [31:0]          len_reg, len_next;
    logic [18:0]          cnt_reg, cnt_next;
    logic [3:0]           pad_reg, pad_next;
    logic [31:0]          crc_reg, crc_next;
    logic [31:0]          rx_reg, rx_next;
    logic                 out_valid_reg;
    ssh1d_pkg::out_item_t item_reg, item_next;
    logic                 emit;
    logic [31:0]          limit;
    logic [31:0]          crc_upd;
    logic [31:0]          len_in;
    logic                 len_bad;

    assign take      = s_valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_item  = item_reg;

    assign limit   = ({13'd0, max_length_reg} > LIMIT_CAP) ? LIMIT_CAP : {13'd0, max_length_reg};
    assign crc_upd = ssh1d_pkg::crc32_byte(crc_reg, s_byte);
    assign len_in  = {len_reg[23:0], s_byte};
    assign len_bad = (len_in > limit) || (len_in < 32'(ssh1d_pkg::MIN_LENGTH));

    always_comb
    begin
        phase_next = phase_reg;
        len_next   = len_reg;
        cnt_next   = cnt_reg;
        pad_next   = pad_reg;
        crc_next   = crc_reg;
        rx_next    = rx_reg;
        case (phase_reg)
            ssh1d_pkg::PH_LENGTH:
            begin
                len_next = len_in;
                cnt_next = cnt_reg + 19'd1;
                if (cnt_reg == 19'd3)
                begin
                    cnt_next = '0;
                    if (len_bad)
                    begin
                        phase_next = ssh1d_pkg::PH_HALTED;
                    end
                    else
                    begin
                        pad_next   = 4'(ssh1d_pkg::PAD_ALIGN) - {1'b0, len_in[2:0]};
                        crc_next   = '0;
                        rx_next    = '0;
                        phase_next = ssh1d_pkg::PH_PADDING;
                    end
                end
            end
            ssh1d_pkg::PH_PADDING:
            begin
                crc_next = crc_upd;
                pad_next = pad_reg - 4'd1;
                if (pad_next == 4'd0)
                begin
                    phase_next = ssh1d_pkg::PH_TYPE;
                end
            end
            ssh1d_pkg::PH_TYPE:
            begin
                crc_next   = crc_upd;
                cnt_next   = len_reg[18:0] - 19'(ssh1d_pkg::MIN_LENGTH);
                phase_next = (cnt_next == '0) ? ssh1d_pkg::PH_CRC : ssh1d_pkg::PH_DATA;
            end
            ssh1d_pkg::PH_DATA:
            begin
                crc_next = crc_upd;
                cnt_next = cnt_reg - 19'd1;
                if (cnt_next == '0)
                begin
                    phase_next = ssh1d_pkg::PH_CRC;
                end
            end
            ssh1d_pkg::PH_CRC:
            begin
                rx_next  = {rx_reg[23:0], s_byte};
                cnt_next = cnt_reg + 19'd1;
                if (cnt_reg == 19'd3)
                begin
                    phase_next = ssh1d_pkg::PH_LENGTH;
                    len_next   = '0;
                    cnt_next   = '0;
                    pad_next   = '0;
                    crc_next   = '0;
                end
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    always_comb
    begin
        emit             = 1'b0;
        item_next.data   = 8'd0;
        item_next.kind   = ssh1d_pkg::KIND_STATUS;
        item_next.status = ssh1d_pkg::ST_OK;
        item_next.last   = 1'b0;
        case (phase_reg)
            ssh1d_pkg::PH_LENGTH:
            begin
                if (cnt_reg == 19'd3 && len_bad)
                begin
                    emit             = 1'b1;
                    item_next.status = ssh1d_pkg::ST_BAD_LEN;
                    item_next.last   = 1'b1;
                end
            end
            ssh1d_pkg::PH_TYPE:
            begin
                emit           = 1'b1;
                item_next.data = s_byte;
                item_next.kind = ssh1d_pkg::KIND_TYPE;
            end
            ssh1d_pkg::PH_DATA:
            begin
                emit           = 1'b1;
                item_next.data = s_byte;
                item_next.kind = ssh1d_pkg::KIND_DATA;
            end
            ssh1d_pkg::PH_CRC:
            begin
                if (cnt_reg == 19'd3)
                begin
                    emit             = 1'b1;
                    item_next.status = (crc_reg == rx_next) ? ssh1d_pkg::ST_OK
                                                            : ssh1d_pkg::ST_BAD_CRC;
                    item_next.last   = 1'b1;
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_length_reg <= 19'd262144;
            phase_reg      <= ssh1d_pkg::PH_LENGTH;
            len_reg        <= '0;
            cnt_reg        <= '0;
            pad_reg        <= '0;
            crc_reg        <= '0;
            rx_reg         <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                max_length_reg <= wr_data;
            end
            if (take)
            begin
                phase_reg     <= phase_next;
                len_reg       <= len_next;
                cnt_reg       <= cnt_next;
                pad_reg       <= pad_next;
                crc_reg       <= crc_next;
                rx_reg        <= rx_next;
                out_valid_reg <= emit;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && emit)
        begin
            item_reg <= item_next;
        end
    end

endmodule

@@ rtl/ssh1_packet_deframer_top.sv @@
// Deframes a plaintext SSH1 byte stream and checks each packet's CRC-32.
// A byte's result passes through the input register and then the result register.
// Throughput: one byte per cycle while the downstream side takes results; the input register
// accepts a new byte in the same cycle as the core takes the old one.
// Reset (asynchronous, active low) clears the pipeline, sets max_length to 262144 and
// waits for a length field; a bad length halts the block until the next reset.
`include "assert_macros.svh"

module ssh1_packet_deframer_top #(
    parameter int MAX_LENGTH_LIMIT = 262144
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  logic [18:0] wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic [1:0]  item_kind,
    output logic [1:0]  status,
    output logic        last
);

    logic                 s_valid;
    logic [7:0]           s_byte;
    logic                 take;
    ssh1d_pkg::out_item_t out_item;

    ssh1d_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_byte  (in_byte),
        .take     (take),
        .s_valid  (s_valid),
        .s_byte   (s_byte)
    );

    ssh1d_core #(
        .MAX_LENGTH_LIMIT (MAX_LENGTH_LIMIT)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_en),
        .wr_data   (wr_data),
        .s_valid   (s_valid),
        .s_byte    (s_byte),
        .take      (take),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_item  (out_item)
    );

    assign out_byte  = out_item.data;
    assign item_kind = out_item.kind;
    assign status    = out_item.status;
    assign last      = out_item.last;

    // A status transaction is the only one that ends a packet.
    `ASSERT_SAME(a_last_on_status, clk, rst_n, out_valid,
        last == (item_kind == ssh1d_pkg::KIND_STATUS))
    // Nothing follows a bad length report.
    `ASSERT_NEXT(a_halt_after_bad_len, clk, rst_n,
        out_valid && out_ready && status == ssh1d_pkg::ST_BAD_LEN, !out_valid)
    // An empty result register never stalls the input side.
    `ASSERT_SAME(a_ready_when_empty, clk, rst_n, !out_valid, in_ready)

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

    localparam int unsigned LEN_CAP = 262144;
    localparam int unsigned CYCLE_LIMIT = 1500000;
    localparam logic [18:0] MAX_REG_VALUE = 19'h7FFFF;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        wr_en = 1'b0;
    logic [18:0] wr_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  in_byte = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  out_byte;
    logic [1:0]  item_kind;
    logic [1:0]  status;
    logic        last;

    logic [7:0]           byte_stream[$];
    ssh1d_pkg::out_item_t pending_items[$];

    ssh1d_pkg::phase_t rx_phase = ssh1d_pkg::PH_LENGTH;
    logic [31:0] len_acc = '0;
    logic [18:0] cnt = '0;
    logic [3:0]  pad_left = '0;
    logic [31:0] crc_acc = '0;
    logic [31:0] crc_rx = '0;
    logic [18:0] cfg_max_len = 19'd262144;

    int unsigned cycle_count = 0;
    int unsigned error_count = 0;
    int unsigned bytes_sent = 0;
    int unsigned packets_sent = 0;
    int unsigned packets_corrupted = 0;
    int unsigned results_checked = 0;
    int unsigned in_gap = 0;
    int unsigned in_calm = 0;
    int unsigned out_stall = 0;
    int unsigned out_calm = 0;
    logic [18:0] mid_limit;

    ssh1_packet_deframer_top #(
        .MAX_LENGTH_LIMIT(LEN_CAP)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .wr_en(wr_en),
        .wr_data(wr_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_byte(in_byte),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_byte(out_byte),
        .item_kind(item_kind),
        .status(status),
        .last(last)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    function automatic logic [31:0] crc32_update(input logic [31:0] c, input logic [7:0] d);
        logic [31:0] r;
        r = c;
        for (int k = 0; k < 8; k++)
        begin
            if (r[0] ^ d[k])
                r = (r >> 1) ^ ssh1d_pkg::CRC_POLY;
            else
                r = r >> 1;
        end
        return r;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t: mismatch: %s", $time, what);
        error_count++;
    endtask

    task automatic queue_result(input logic [7:0] b, input ssh1d_pkg::kind_t k,
                                input ssh1d_pkg::status_t s, input logic l);
        ssh1d_pkg::out_item_t item;
        item.data = b;
        item.kind = k;
        item.status = s;
        item.last = l;
        pending_items.push_back(item);
    endtask

    task automatic deframe_byte(input logic [7:0] b);
        logic [31:0] eff_limit;
        logic [31:0] total;
        case (rx_phase)
            ssh1d_pkg::PH_LENGTH:
            begin
                len_acc = {len_acc[23:0], b};
                cnt = cnt + 19'd1;
                if (cnt == 19'd4)
                begin
                    cnt = '0;
                    eff_limit = (cfg_max_len > LEN_CAP) ? LEN_CAP : {13'd0, cfg_max_len};
                    if (len_acc > eff_limit || len_acc < ssh1d_pkg::MIN_LENGTH)
                    begin
                        rx_phase = ssh1d_pkg::PH_HALTED;
                        queue_result(8'd0, ssh1d_pkg::KIND_STATUS, ssh1d_pkg::ST_BAD_LEN, 1'b1);
                    end
                    else
                    begin
                        total = (len_acc + ssh1d_pkg::PAD_ALIGN) & ~32'd7;
                        pad_left = 4'(total - len_acc);
                        crc_acc = '0;
                        crc_rx = '0;
                        rx_phase = ssh1d_pkg::PH_PADDING;
                    end
                end
            end
            ssh1d_pkg::PH_PADDING:
            begin
                crc_acc = crc32_update(crc_acc, b);
                pad_left = pad_left - 4'd1;
                if (pad_left == 4'd0)
                    rx_phase = ssh1d_pkg::PH_TYPE;
            end
            ssh1d_pkg::PH_TYPE:
            begin
                crc_acc = crc32_update(crc_acc, b);
                cnt = 19'(len_acc - ssh1d_pkg::MIN_LENGTH);
                rx_phase = (cnt == '0) ? ssh1d_pkg::PH_CRC : ssh1d_pkg::PH_DATA;
                queue_result(b, ssh1d_pkg::KIND_TYPE, ssh1d_pkg::ST_OK, 1'b0);
            end
            ssh1d_pkg::PH_DATA:
            begin
                crc_acc = crc32_update(crc_acc, b);
                cnt = cnt - 19'd1;
                if (cnt == '0)
                    rx_phase = ssh1d_pkg::PH_CRC;
                queue_result(b, ssh1d_pkg::KIND_DATA, ssh1d_pkg::ST_OK, 1'b0);
            end
            ssh1d_pkg::PH_CRC:
            begin
                crc_rx = {crc_rx[23:0], b};
                cnt = cnt + 19'd1;
                if (cnt == 19'd4)
                begin
                    queue_result(8'd0, ssh1d_pkg::KIND_STATUS,
                                 (crc_acc == crc_rx) ? ssh1d_pkg::ST_OK
                                                     : ssh1d_pkg::ST_BAD_CRC, 1'b1);
                    rx_phase = ssh1d_pkg::PH_LENGTH;
                    len_acc = '0;
                    cnt = '0;
                    pad_left = '0;
                    crc_acc = '0;
                end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic push_byte(input logic [7:0] b);
        byte_stream.push_back(b);
        bytes_sent++;
    endtask

    task automatic push_length(input logic [31:0] len);
        push_byte(len[31:24]);
        push_byte(len[23:16]);
        push_byte(len[15:8]);
        push_byte(len[7:0]);
    endtask

    task automatic add_packet(input int unsigned len, input bit corrupt);
        int unsigned pad;
        logic [31:0] crc;
        logic [7:0] v;
        push_length(len);
        pad = ((len + 8) & ~32'd7) - len;
        crc = '0;
        for (int i = 0; i < pad + len - 4; i++)
        begin
            v = 8'($urandom);
            push_byte(v);
            crc = crc32_update(crc, v);
        end
        if (corrupt)
        begin
            crc = crc ^ (32'd1 << $urandom_range(0, 31));
            packets_corrupted++;
        end
        push_length(crc);
        packets_sent++;
    endtask

    task automatic send_random_packets(input int unsigned min_bytes, input int unsigned lim);
        int unsigned start;
        int unsigned r;
        int unsigned len;
        start = bytes_sent;
        while (bytes_sent - start < min_bytes)
        begin
            r = $urandom_range(0, 99);
            if (r < 75)
                len = $urandom_range(5, (lim < 40) ? lim : 40);
            else if (r < 95)
                len = $urandom_range(5, (lim < 300) ? lim : 300);
            else if (lim <= 300)
                len = lim;
            else
                len = $urandom_range(5, 600);
            add_packet(len, $urandom_range(0, 6) == 0);
        end
    endtask

    task automatic wait_idle(input int unsigned extra);
        while (byte_stream.size() != 0 || in_valid || pending_items.size() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_max_len(input logic [18:0] value);
        @(posedge clk);
        wr_en <= 1'b1;
        wr_data <= value;
        @(posedge clk);
        wr_en <= 1'b0;
        cfg_max_len = value;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_gap <= 0;
        end
        else if (!in_valid || in_ready)
        begin
            if (in_gap != 0)
            begin
                in_valid <= 1'b0;
                in_gap <= in_gap - 1;
            end
            else if (byte_stream.size() != 0)
            begin
                in_valid <= 1'b1;
                in_byte <= byte_stream.pop_front();
                if (in_calm != 0)
                begin
                    in_calm <= in_calm - 1;
                    in_gap <= 0;
                end
                else if ($urandom_range(0, 149) == 0)
                begin
                    in_calm <= $urandom_range(40, 120);
                    in_gap <= 0;
                end
                else
                    in_gap <= pick_gap();
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_stall <= 0;
        end
        else if (out_stall != 0)
        begin
            out_ready <= 1'b0;
            out_stall <= out_stall - 1;
        end
        else
        begin
            out_ready <= 1'b1;
            if (out_calm != 0)
                out_calm <= out_calm - 1;
            else if ($urandom_range(0, 149) == 0)
                out_calm <= $urandom_range(40, 120);
            else if ($urandom_range(0, 3) == 0)
                out_stall <= pick_gap();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            deframe_byte(in_byte);
    end

    always @(posedge clk)
    begin : result_check
        ssh1d_pkg::out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_items.size() == 0)
                report_mismatch($sformatf("unexpected result byte %02h kind %0d status %0d last %0d",
                                          out_byte, item_kind, status, last));
            else
            begin
                want = pending_items.pop_front();
                results_checked++;
                if (out_byte !== want.data)
                    report_mismatch($sformatf("out_byte %02h, expected %02h", out_byte, want.data));
                if (item_kind !== want.kind)
                    report_mismatch($sformatf("item_kind %0d, expected %0d", item_kind, want.kind));
                if (status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
                if (last !== want.last)
                    report_mismatch($sformatf("last %0d, expected %0d", last, want.last));
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("%0t: timeout with %0d results still expected", $time, pending_items.size());
        $display("tb_top: FAIL");
        $finish;
    end

    initial
    begin : stimulus
        int unsigned halt_mode;
        logic [31:0] bad_len;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_packet(5, 1'b0);
        add_packet(7, 1'b1);
        send_random_packets(480, LEN_CAP);
        wait_idle(6);

        write_max_len(MAX_REG_VALUE);
        send_random_packets(400, LEN_CAP);
        wait_idle(6);

        write_max_len(19'd5);
        send_random_packets(250, 5);
        wait_idle(6);

        mid_limit = 19'($urandom_range(6, 250));
        write_max_len(mid_limit);
        send_random_packets(480, mid_limit);
        wait_idle(6);

        halt_mode = $urandom_range(0, 2);
        if (halt_mode == 0)
        begin
            write_max_len(19'($urandom_range(0, 4)));
            bad_len = $urandom_range(5, 300);
        end
        else if (halt_mode == 1)
        begin
            write_max_len(MAX_REG_VALUE);
            bad_len = $urandom_range(0, 1) ? 32'hFFFFFFFF : LEN_CAP + 1;
        end
        else
            bad_len = $urandom_range(0, 4);
        push_length(bad_len);
        repeat (6) push_byte(8'($urandom));
        wait_idle(10);

        $display("Summary: %0d bytes in %0d packets (%0d with a corrupted CRC), %0d results checked.",
                 bytes_sent, packets_sent, packets_corrupted, results_checked);
        $display("Summary: limits 262144, saturated, 5 and %0d, then a halting length 0x%08h.",
                 mid_limit, bad_len);
        if (error_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/ssh1d_pkg.sv
rtl/ssh1d_in_stage.sv
rtl/ssh1d_core.sv
rtl/ssh1_packet_deframer_top.sv
bench/tb_top.sv
